FILE: design/gsig_pkg.sv
// ----------------------------------------------------------------------------
// gsig_pkg
// Shared widths, register indexes, command/status types and helpers for the
// grid strip index generator.
// ----------------------------------------------------------------------------
package gsig_pkg;

    localparam int MAX_MAP     = 1024;
    localparam int MAX_SQUARES = 5;

    localparam int CFG_W    = $clog2(MAX_MAP) + 1;      // map size register width
    localparam int CNT_W    = 3;                        // square count register width
    localparam int ORG_W    = $clog2(MAX_MAP);          // chunk origin width
    localparam int EXT_W    = $clog2(MAX_MAP) + 1;      // chunk extent width
    localparam int COORD_W  = EXT_W + 3;                // running grid coordinate
    localparam int SIDE_W   = EXT_W + 2;                // signed square side
    localparam int PT_W     = COORD_W + 2;              // signed grid point
    localparam int PROD_W   = PT_W + CFG_W + 1;
    localparam int IDX_W    = 22;
    localparam int POS_W    = 24;
    localparam int DIV_STEPS = EXT_W;
    localparam int DCNT_W   = $clog2(DIV_STEPS);

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    // configuration register indexes
    localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SQUARES_X  = 2'd2;
    localparam logic [1:0] CFG_SQUARES_Y  = 2'd3;

    // which corner of the current square an index refers to
    typedef enum logic [1:0] {
        K_FIRST = 2'd0,
        K_LEAD  = 2'd1,
        K_P1    = 2'd2,
        K_P2    = 2'd3
    } t_kind;

    typedef struct packed {
        logic  load;
        logic  div_step;
        logic  emit;
        t_kind kind;
        logic  odd;
        logic  last;
        logic  step_sq;
        logic  step_row;
    } t_cmd;

    typedef struct packed {
        logic adv;
    } t_sts;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] r;
        if (n == '0) begin
            r = CNT_W'(1);
        end else if (n > CNT_W'(MAX_SQUARES)) begin
            r = CNT_W'(MAX_SQUARES);
        end else begin
            r = n;
        end
        return r;
    endfunction

endpackage

FILE: design/gsig_div.sv
// ----------------------------------------------------------------------------
// gsig_div
// Restoring divider, one quotient bit per step, for a chunk extent over a
// small square count.
// ----------------------------------------------------------------------------
module gsig_div (
    input  logic                       i_clk,
    input  logic                       i_start,
    input  logic                       i_step,
    input  logic [gsig_pkg::EXT_W-1:0] i_dividend,
    input  logic [gsig_pkg::CNT_W-1:0] i_divisor,
    output logic [gsig_pkg::EXT_W-1:0] o_quot
);
    import gsig_pkg::*;

    logic [EXT_W-1:0] r_shift;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W:0]   w_trial;
    logic             w_fit;
    logic [CNT_W:0]   w_diff;

    assign w_trial = {r_rem, r_shift[EXT_W-1]};
    assign w_fit   = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    // shift register holds remaining dividend bits and collects quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (i_step) begin
            r_shift <= {r_shift[EXT_W-2:0], w_fit};
            r_rem   <= w_fit ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
        end
    end

    assign o_quot = r_shift;

endmodule

FILE: design/gsig_datapath.sv
// ----------------------------------------------------------------------------
// gsig_datapath
// Square geometry, edge shrink, index arithmetic pipeline and buffer slot
// counter.
// ----------------------------------------------------------------------------
module gsig_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gsig_pkg::t_cmd              i_cmd,
    output gsig_pkg::t_sts              o_sts,
    input  logic [gsig_pkg::ORG_W-1:0]  i_chunk_x,
    input  logic [gsig_pkg::ORG_W-1:0]  i_chunk_y,
    input  logic [gsig_pkg::EXT_W-1:0]  i_chunk_w,
    input  logic [gsig_pkg::EXT_W-1:0]  i_chunk_h,
    input  logic [gsig_pkg::CFG_W-1:0]  i_map_width,
    input  logic [gsig_pkg::CFG_W-1:0]  i_map_height,
    input  logic [gsig_pkg::CNT_W-1:0]  i_squares_x,
    input  logic [gsig_pkg::CNT_W-1:0]  i_squares_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [gsig_pkg::IDX_W-1:0] o_vertex_index,
    output logic [gsig_pkg::POS_W-1:0]  o_position,
    output logic                        o_last
);
    import gsig_pkg::*;

    logic [EXT_W-1:0]   w_qx, w_qy, w_xs0, w_ys0;
    logic [COORD_W-1:0] r_xp, r_yp, n_xp, n_yp;
    logic [COORD_W:0]   w_xsum, w_ysum;
    logic               w_edge_x, w_edge_y;
    logic signed [SIDE_W-1:0] w_xs, w_ys;
    logic signed [PT_W-1:0]   w_x_near, w_x_far, w_y_near, w_y_far, w_col, w_row;
    logic               w_adv;
    logic [POS_W-1:0]   r_fill;

    logic                     r_a_valid, r_b_valid, r_c_valid;
    logic signed [PT_W-1:0]   r_a_col, r_a_row, r_b_row;
    logic [POS_W-1:0]         r_a_pos, r_b_pos, r_c_pos;
    logic                     r_a_last, r_b_last, r_c_last;
    logic signed [PROD_W-1:0] w_prod;
    logic [IDX_W-1:0]         r_b_prod;
    logic signed [IDX_W-1:0]  r_c_idx;

    gsig_div u_div_x (
        .i_clk      (i_clk),
        .i_start    (i_cmd.load),
        .i_step     (i_cmd.div_step),
        .i_dividend (i_chunk_w),
        .i_divisor  (clamp_count(i_squares_x)),
        .o_quot     (w_qx)
    );

    gsig_div u_div_y (
        .i_clk      (i_clk),
        .i_start    (i_cmd.load),
        .i_step     (i_cmd.div_step),
        .i_dividend (i_chunk_h),
        .i_divisor  (clamp_count(i_squares_y)),
        .o_quot     (w_qy)
    );

    // nominal square side is at least one; at the map edge it drops to q-1
    assign w_xs0    = (w_qx == '0) ? EXT_W'(1) : w_qx;
    assign w_ys0    = (w_qy == '0) ? EXT_W'(1) : w_qy;
    assign w_xsum   = {1'b0, r_xp} + (COORD_W+1)'(w_xs0);
    assign w_ysum   = {1'b0, r_yp} + (COORD_W+1)'(w_ys0);
    assign w_edge_x = w_xsum >= (COORD_W+1)'(i_map_width);
    assign w_edge_y = w_ysum >= (COORD_W+1)'(i_map_height);
    assign w_xs = w_edge_x ? $signed({2'b00, w_qx}) - SIDE_W'(1) : $signed({2'b00, w_xs0});
    assign w_ys = w_edge_y ? $signed({2'b00, w_qy}) - SIDE_W'(1) : $signed({2'b00, w_ys0});

    assign w_x_near = $signed({2'b00, r_xp});
    assign w_y_near = $signed({2'b00, r_yp});
    assign w_x_far  = w_x_near + PT_W'(w_xs);
    assign w_y_far  = w_y_near + PT_W'(w_ys);

    always_comb begin
        unique case (i_cmd.kind)
            K_FIRST: begin
                w_col = w_x_near;
                w_row = w_y_near;
            end
            K_LEAD: begin
                w_col = w_x_far;
                w_row = i_cmd.odd ? w_y_far : w_y_near;
            end
            K_P1: begin
                w_col = w_x_near;
                w_row = i_cmd.odd ? w_y_near : w_y_far;
            end
            K_P2: begin
                w_col = w_x_far;
                w_row = i_cmd.odd ? w_y_near : w_y_far;
            end
            default: begin
                w_col = w_x_near;
                w_row = w_y_near;
            end
        endcase
    end

    // serpentine walk: rows advance x, squares move y up on even rows, down on odd
    always_comb begin
        n_xp = r_xp;
        n_yp = r_yp;
        if (i_cmd.load) begin
            n_xp = COORD_W'(i_chunk_x);
            n_yp = COORD_W'(i_chunk_y);
        end else if (i_cmd.emit && i_cmd.step_row) begin
            n_xp = r_xp + COORD_W'(w_xs0);
        end else if (i_cmd.emit && i_cmd.step_sq) begin
            n_yp = i_cmd.odd ? r_yp - COORD_W'(w_ys0) : r_yp + COORD_W'(w_ys0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_xp <= n_xp;
        r_yp <= n_yp;
    end

    // whole pipe moves together when the output register is free or taken
    assign w_adv     = !r_c_valid || i_ready;
    assign o_sts.adv = w_adv;
    assign w_prod    = r_a_col * $signed({1'b0, i_map_height});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_fill    <= '0;
        end else if (w_adv) begin
            r_a_valid <= i_cmd.emit;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            if (i_cmd.emit) begin
                r_fill <= r_fill + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_col  <= w_col;
            r_a_row  <= w_row;
            r_a_pos  <= r_fill;
            r_a_last <= i_cmd.last;
            r_b_prod <= w_prod[IDX_W-1:0];
            r_b_row  <= r_a_row;
            r_b_pos  <= r_a_pos;
            r_b_last <= r_a_last;
            r_c_idx  <= $signed(r_b_prod) + IDX_W'(r_b_row);
            r_c_pos  <= r_b_pos;
            r_c_last <= r_b_last;
        end
    end

    assign o_valid        = r_c_valid;
    assign o_vertex_index = r_c_idx;
    assign o_position     = r_c_pos;
    assign o_last         = r_c_last;

endmodule

FILE: design/gsig_ctrl.sv
// ----------------------------------------------------------------------------
// gsig_ctrl
// Sequencer: accepts a chunk, runs the divide, then walks rows and squares
// issuing one index per cycle while the datapath pipe advances.
// ----------------------------------------------------------------------------
module gsig_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [gsig_pkg::CNT_W-1:0] i_squares_x,
    input  logic [gsig_pkg::CNT_W-1:0] i_squares_y,
    input  gsig_pkg::t_sts             i_sts,
    output gsig_pkg::t_cmd             o_cmd
);
    import gsig_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_i, n_i, r_j, n_j;
    t_kind            r_kind, n_kind;
    logic [CNT_W-1:0] w_nx, w_ny;

    assign w_nx = clamp_count(i_squares_x);
    assign w_ny = clamp_count(i_squares_y);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_kind  = r_kind;
        o_cmd          = '0;
        o_cmd.kind     = r_kind;
        o_cmd.odd      = r_i[0];
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + DCNT_W'(1);
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_EMIT;
                    n_kind  = K_FIRST;
                    n_i     = '0;
                    n_j     = '0;
                end
            end
            ST_EMIT: begin
                if (i_sts.adv) begin
                    o_cmd.emit = 1'b1;
                    unique case (r_kind)
                        K_FIRST: n_kind = K_LEAD;
                        K_LEAD:  n_kind = K_P1;
                        K_P1:    n_kind = K_P2;
                        K_P2: begin
                            if (r_j == w_ny - CNT_W'(1)) begin
                                if (r_i == w_nx - CNT_W'(1)) begin
                                    o_cmd.last = 1'b1;
                                    n_state    = ST_IDLE;
                                end else begin
                                    o_cmd.step_row = 1'b1;
                                    n_i    = r_i + CNT_W'(1);
                                    n_j    = '0;
                                    n_kind = K_LEAD;
                                end
                            end else begin
                                o_cmd.step_sq = 1'b1;
                                n_j    = r_j + CNT_W'(1);
                                n_kind = K_P1;
                            end
                        end
                        default: n_kind = K_FIRST;
                    endcase
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_kind  <= K_FIRST;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_kind  <= n_kind;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

endmodule

FILE: design/grid_strip_index_generator.sv
// ----------------------------------------------------------------------------
// grid_strip_index_generator
// Triangle-strip vertex indices for one heightmap chunk per request.
// ----------------------------------------------------------------------------
// A chunk request yields N = 1 + nx*(2*ny+1) indices (at most 56): a load,
// then the bit-serial dividers size the squares, then the sequencer issues
// one index per cycle while the output is not stalled. The next request is
// taken as soon as the last index is issued; the last three indices drain
// through the index pipeline while the next divide runs. Output backpressure
// stalls the whole index pipeline. The buffer slot counter runs across
// chunks and wraps at 2^24.
module grid_strip_index_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // chunk_x[9:0], chunk_y[19:10], chunk_w[30:20], chunk_h[41:31], zero pad
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [gsig_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // vertex_index[21:0], position[45:22], zero pad
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [gsig_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_addr,
    input  logic [gsig_pkg::CFG_W-1:0]          i_cfg_data
);
    import gsig_pkg::*;

    logic [CFG_W-1:0] r_map_width, r_map_height;
    logic [CNT_W-1:0] r_squares_x, r_squares_y;
    t_cmd             w_cmd;
    t_sts             w_sts;
    logic signed [IDX_W-1:0] w_idx;
    logic [POS_W-1:0] w_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= CFG_W'(MAX_MAP);
            r_map_height <= CFG_W'(MAX_MAP);
            r_squares_x  <= CNT_W'(4);
            r_squares_y  <= CNT_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                CFG_SQUARES_X:  r_squares_x  <= i_cfg_data[CNT_W-1:0];
                CFG_SQUARES_Y:  r_squares_y  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    gsig_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_squares_x (r_squares_x),
        .i_squares_y (r_squares_y),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    gsig_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_chunk_x      (i_s_tdata[ORG_W-1:0]),
        .i_chunk_y      (i_s_tdata[2*ORG_W-1:ORG_W]),
        .i_chunk_w      (i_s_tdata[2*ORG_W+EXT_W-1:2*ORG_W]),
        .i_chunk_h      (i_s_tdata[2*ORG_W+2*EXT_W-1:2*ORG_W+EXT_W]),
        .i_map_width    (r_map_width),
        .i_map_height   (r_map_height),
        .i_squares_x    (r_squares_x),
        .i_squares_y    (r_squares_y),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_vertex_index (w_idx),
        .o_position     (w_pos),
        .o_last         (o_m_tlast)
    );

    assign o_m_tdata = {(OUT_DATA_W-IDX_W-POS_W)'(0), w_pos, w_idx};

endmodule

FILE: design/gsig_checker.sv
// ----------------------------------------------------------------------------
// gsig_checker
// Port-level checks for the grid strip index generator.
// ----------------------------------------------------------------------------
module gsig_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [gsig_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                            o_m_tlast
);
    import gsig_pkg::*;

    logic [POS_W-1:0] r_exp_pos;
    logic [1:0]       r_open;
    logic             w_in_beat, w_out_beat;

    assign w_in_beat  = i_s_tvalid && o_s_tready;
    assign w_out_beat = o_m_tvalid && i_m_tready;

    // model of the slot counter and of chunks not yet closed by tlast
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_pos <= '0;
            r_open    <= '0;
        end else begin
            if (w_out_beat) begin
                r_exp_pos <= r_exp_pos + POS_W'(1);
            end
            r_open <= r_open + 2'(w_in_beat) - 2'(w_out_beat && o_m_tlast);
        end
    end

    a_pos_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[IDX_W+POS_W-1:IDX_W] == r_exp_pos)
        else $error("buffer slot out of sequence");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_open != 2'd0)
        else $error("index beat with no open chunk");

    a_divide_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !o_s_tready)
        else $error("request taken during divide");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("stalled beat changed");

endmodule

bind grid_strip_index_generator gsig_checker u_gsig_checker (.*);

FILE: dv/grid_strip_index_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_strip_index_generator_test
// Streams chunk requests into the generator and checks every strip index,
// buffer slot and end-of-chunk flag against an in-bench model of the
// serpentine walk. Covers reset geometry, saturated square counts, odd map
// sizes, edge shrink, index wrap, output backpressure and random traffic
// over several register settings.
// ----------------------------------------------------------------------------
module grid_strip_index_generator_test;

    import gsig_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD = 600;
    localparam longint LIMIT_NS = 64'd20_000_000;

    typedef struct {
        logic [IDX_W-1:0] vertex_index;
        logic [POS_W-1:0] position;
        logic             last;
    } t_strip_index;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_addr = CFG_MAP_WIDTH;
    logic [CFG_W-1:0]      cfg_data = '0;

    // register shadow and running buffer slot
    int unsigned      map_w = MAX_MAP;
    int unsigned      map_h = MAX_MAP;
    logic [CNT_W-1:0] rows_per_chunk = 3'd4;
    logic [CNT_W-1:0] squares_per_row = 3'd4;
    logic [POS_W-1:0] fill_slot = '0;

    t_strip_index strip_q[$];
    int           err_count = 0;
    bit           sender_gaps = 1'b1;
    bit           sink_stalls = 1'b1;
    bit           long_hold_req = 1'b0;

    grid_strip_index_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int sat_count(logic [CNT_W-1:0] n);
        int r;
        r = int'(n);
        if (r < 1) begin
            r = 1;
        end else if (r > MAX_SQUARES) begin
            r = MAX_SQUARES;
        end
        return r;
    endfunction

    function automatic void push_index(int col, int row);
        int           v;
        t_strip_index e;
        v = col * int'(map_h) + row;
        e.vertex_index = v[IDX_W-1:0];
        e.position = fill_slot;
        e.last = 1'b0;
        strip_q.insert(strip_q.size(), e);
        fill_slot = fill_slot + 1'b1;
    endfunction

    // serpentine walk: even rows forward, odd rows mirrored
    function automatic void predict_strip(logic [ORG_W-1:0] cx, logic [ORG_W-1:0] cy,
                                          logic [EXT_W-1:0] cw, logic [EXT_W-1:0] ch);
        int nx, ny, qx, qy, xs, ys, xp, yp, line, x, y;
        x = int'(cx);
        y = int'(cy);
        nx = sat_count(rows_per_chunk);
        ny = sat_count(squares_per_row);
        qx = int'(cw) / nx;
        qy = int'(ch) / ny;
        push_index(x, y);
        for (int i = 0; i < nx; i++) begin
            for (int j = 0; j < ny; j++) begin
                line = (i % 2 == 0) ? j : ny - 1 - j;
                xs = (qx < 1) ? 1 : qx;
                ys = (qy < 1) ? 1 : qy;
                xp = i * xs + x;
                yp = line * ys + y;
                // edge shrink may go to -1 when the quotient is zero
                if (xp + xs >= int'(map_w)) xs = qx - 1;
                if (yp + ys >= int'(map_h)) ys = qy - 1;
                if (i % 2 == 0) begin
                    if (j == 0) push_index(xp + xs, yp);
                    push_index(xp, yp + ys);
                    push_index(xp + xs, yp + ys);
                end else begin
                    if (j == 0) push_index(xp + xs, yp + ys);
                    push_index(xp, yp);
                    push_index(xp + xs, yp);
                end
            end
        end
        strip_q[strip_q.size()-1].last = 1'b1;
    endfunction

    task automatic send_chunk(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, h[EXT_W-1:0], w[EXT_W-1:0], y[ORG_W-1:0], x[ORG_W-1:0]};
        do @(posedge i_clk); while (!s_tready);
        predict_strip(x[ORG_W-1:0], y[ORG_W-1:0], w[EXT_W-1:0], h[EXT_W-1:0]);
    endtask

    // called in the step of the last accepted beat, so valid drops right away
    task automatic settle();
        s_tvalid <= 1'b0;
        while (strip_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] addr, int unsigned val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= val[CFG_W-1:0];
        case (addr)
            CFG_MAP_WIDTH:  map_w = val & 32'h7FF;
            CFG_MAP_HEIGHT: map_h = val & 32'h7FF;
            CFG_SQUARES_X:  rows_per_chunk = val[CNT_W-1:0];
            CFG_SQUARES_Y:  squares_per_row = val[CNT_W-1:0];
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned mw, int unsigned mh, int unsigned sx,
                                int unsigned sy);
        write_reg(CFG_MAP_WIDTH, mw);
        write_reg(CFG_MAP_HEIGHT, mh);
        write_reg(CFG_SQUARES_X, sx);
        write_reg(CFG_SQUARES_Y, sy);
    endtask

    function automatic int unsigned pick_map_size();
        int unsigned r;
        case ($urandom_range(0, 4))
            0:       r = 1;
            1:       r = MAX_MAP;
            2:       r = $urandom_range(2, 40);
            default: r = $urandom_range(1, MAX_MAP);
        endcase
        return r;
    endfunction

    task automatic random_chunk();
        int unsigned x, y, w, h;
        case ($urandom_range(0, 7))
            0: begin
                x = $urandom_range(0, MAX_MAP - 1);
                y = $urandom_range(0, MAX_MAP - 1);
                w = $urandom_range(0, MAX_MAP);
                h = $urandom_range(0, MAX_MAP);
            end
            1: begin
                x = $urandom_range(0, 1) ? MAX_MAP - 1 : 0;
                y = $urandom_range(0, 1) ? MAX_MAP - 1 : 0;
                w = $urandom_range(0, 1) ? MAX_MAP : 0;
                h = $urandom_range(0, 1) ? MAX_MAP : 0;
            end
            default: begin
                // chunk inside the map, often hugging its far edge
                x = $urandom_range(0, 2) == 0 ? map_w - 1 - $urandom_range(0, (map_w - 1) % 8)
                                              : $urandom_range(0, map_w - 1);
                y = $urandom_range(0, 2) == 0 ? map_h - 1 - $urandom_range(0, (map_h - 1) % 8)
                                              : $urandom_range(0, map_h - 1);
                w = $urandom_range(0, 2) == 0 ? $urandom_range(0, 12)
                                              : $urandom_range(0, map_w - x);
                h = $urandom_range(0, 2) == 0 ? $urandom_range(0, 12)
                                              : $urandom_range(0, map_h - y);
            end
        endcase
        send_chunk(x, y, w, h);
    endtask

    // sink: random stall bursts, plus one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                long_hold_req = 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_strip_index e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (strip_q.size() == 0) begin
                $error("unexpected index beat: tdata %h tlast %b", m_tdata, m_tlast);
                err_count++;
            end else begin
                e = strip_q.pop_front();
                if (m_tdata[IDX_W-1:0] !== e.vertex_index) begin
                    $error("vertex_index: expected %h, got %h", e.vertex_index,
                           m_tdata[IDX_W-1:0]);
                    err_count++;
                end
                if (m_tdata[IDX_W+POS_W-1:IDX_W] !== e.position) begin
                    $error("position: expected %0d, got %0d", e.position,
                           m_tdata[IDX_W+POS_W-1:IDX_W]);
                    err_count++;
                end
                if (m_tlast !== e.last) begin
                    $error("last: expected %b, got %b", e.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    task automatic test_reset_geometry();
        send_chunk(0, 0, 0, 0);
        send_chunk(MAX_MAP - 1, MAX_MAP - 1, MAX_MAP, MAX_MAP);
        send_chunk(0, 0, MAX_MAP, MAX_MAP);
        send_chunk(512, 256, 100, 37);
        settle();
    endtask

    task automatic test_square_counts();
        set_geometry(MAX_MAP, MAX_MAP, 1, 1);
        send_chunk(10, 20, 30, 40);
        settle();
        set_geometry(MAX_MAP, MAX_MAP, MAX_SQUARES, MAX_SQUARES);
        send_chunk(100, 200, 1000, 999);
        settle();
        // zero acts as one, above the maximum saturates
        set_geometry(MAX_MAP, MAX_MAP, 0, 7);
        send_chunk(3, 5, 17, 23);
        settle();
        set_geometry(MAX_MAP, MAX_MAP, 6, 0);
        send_chunk(3, 5, 17, 23);
        settle();
        set_geometry(MAX_MAP, MAX_MAP, MAX_SQUARES, 1);
        send_chunk(1000, 7, 24, 5);
        settle();
        set_geometry(MAX_MAP, MAX_MAP, 2, 3);
        send_chunk(1, 1000, 8, 24);
        settle();
    endtask

    task automatic test_map_extremes();
        set_geometry(1, 1, 2, 2);
        send_chunk(0, 0, 0, 0);
        send_chunk(0, 0, 5, 5);
        settle();
        // out-of-range sizes are used as given
        set_geometry(0, 0, 3, 3);
        send_chunk(0, 0, 2, 2);
        send_chunk(7, 9, 40, 40);
        settle();
        // large stride: index nears the top of its 22 bits
        set_geometry(2047, 2047, MAX_SQUARES, MAX_SQUARES);
        send_chunk(MAX_MAP - 1, MAX_MAP - 1, MAX_MAP, MAX_MAP);
        send_chunk(MAX_MAP - 1, 0, 1, MAX_MAP);
        settle();
        // shrink to -1 at the edge with zero quotient
        set_geometry(20, 20, 4, 4);
        send_chunk(18, 18, 2, 3);
        send_chunk(19, 0, 0, 0);
        settle();
    endtask

    task automatic test_backpressure();
        set_geometry(MAX_MAP, MAX_MAP, MAX_SQUARES, MAX_SQUARES);
        long_hold_req = 1'b1;
        repeat (20) random_chunk();
        settle();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 8; p++) begin
            set_geometry(pick_map_size(), pick_map_size(), $urandom_range(0, 7),
                         $urandom_range(0, 7));
            sender_gaps = $urandom_range(0, 3) != 0;
            sink_stalls = $urandom_range(0, 3) != 0;
            repeat (40) random_chunk();
            settle();
        end
    endtask

    task automatic test_quiet_tail();
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        set_geometry(pick_map_size(), pick_map_size(), $urandom_range(1, MAX_SQUARES),
                     $urandom_range(1, MAX_SQUARES));
        repeat (30) random_chunk();
        settle();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_geometry();
        test_square_counts();
        test_map_extremes();
        test_backpressure();
        test_random_traffic();
        test_quiet_tail();
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
design/gsig_pkg.sv
design/gsig_div.sv
design/gsig_datapath.sv
design/gsig_ctrl.sv
design/grid_strip_index_generator.sv
design/gsig_checker.sv
dv/grid_strip_index_generator_test.sv
